// File: rtl/arlt_pkg.sv
// arlt_pkg: shared types, codes and response pattern tables for the AT response line tracker
// no dependencies

package arlt_pkg;

   localparam int PAT_LEN = 12;
   localparam int NPAT    = 24;

   localparam logic [4:0] PAT_AT        = 5'd0;
   localparam logic [4:0] PAT_OK        = 5'd1;
   localparam logic [4:0] PAT_ERROR     = 5'd2;
   localparam logic [4:0] PAT_CME       = 5'd3;
   localparam logic [4:0] PAT_CMS       = 5'd4;
   localparam logic [4:0] PAT_SEND_OK   = 5'd5;
   localparam logic [4:0] PAT_SEND_FAIL = 5'd6;
   localparam int         PAT_URC_FIRST = 7;

   localparam logic [7:0] CH_BS  = 8'h08;
   localparam logic [7:0] CH_NL  = 8'h0A;
   localparam logic [7:0] CH_SP  = 8'h20;
   localparam logic [7:0] CH_GT  = 8'h3E;
   localparam logic [7:0] CH_DEL = 8'h7F;

   typedef enum logic [1:0] {
      OP_BYTE = 2'd0,
      OP_REG  = 2'd1,
      OP_TICK = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_ACCEPTED  = 3'd0,
      KIND_FULL      = 3'd1,
      KIND_ECHO      = 3'd2,
      KIND_DATA      = 3'd3,
      KIND_FINAL     = 3'd4,
      KIND_TIMEOUT   = 3'd5,
      KIND_URC       = 3'd6,
      KIND_UNMATCHED = 3'd7
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REG,
      ST_TS_RD,
      ST_TS_CK,
      ST_TE_RD,
      ST_TE_CK,
      ST_M_RD,
      ST_M_CK,
      ST_DECIDE,
      ST_TMO
   } state_type;

   typedef struct packed {
      logic echo;
      logic final_rsp;
      logic fail;
      logic urc;
   } class_type;

   function automatic logic [95:0] pat_text(input logic [4:0] p);
      logic [95:0] t;
      unique case (p)
         5'd0:    t = "AT";
         5'd1:    t = "OK";
         5'd2:    t = "ERROR";
         5'd3:    t = "+CME ERROR:";
         5'd4:    t = "+CMS ERROR:";
         5'd5:    t = "SEND OK";
         5'd6:    t = "SEND FAIL";
         5'd7:    t = "+CREG:";
         5'd8:    t = "+CGREG:";
         5'd9:    t = "+CEREG:";
         5'd10:   t = "+CSQ:";
         5'd11:   t = "+CGEV:";
         5'd12:   t = "+CIPOPEN:";
         5'd13:   t = "+CIPRCV:";
         5'd14:   t = "+CIPCLOSE:";
         5'd15:   t = "+CIPERROR:";
         5'd16:   t = "+CDNSGIP:";
         5'd17:   t = "+NETOPEN:";
         5'd18:   t = "+NETCLOSE:";
         5'd19:   t = "+CADATAIND:";
         5'd20:   t = "+CGDCONT:";
         5'd21:   t = "+CPIN:";
         5'd22:   t = "+HTTPACTION:";
         5'd23:   t = "+HTTPSTATUS:";
         default: t = '0;
      endcase
      return t;
   endfunction

   function automatic logic [3:0] pat_len(input logic [4:0] p);
      logic [3:0] l;
      unique case (p)
         5'd0, 5'd1:                       l = 4'd2;
         5'd2, 5'd10:                      l = 4'd5;
         5'd3, 5'd4, 5'd19:                l = 4'd11;
         5'd5, 5'd8, 5'd9:                 l = 4'd7;
         5'd6, 5'd12, 5'd16, 5'd17, 5'd20: l = 4'd9;
         5'd7, 5'd11, 5'd21:               l = 4'd6;
         5'd13:                            l = 4'd8;
         5'd14, 5'd15, 5'd18:              l = 4'd10;
         5'd22, 5'd23:                     l = 4'd12;
         default:                          l = 4'd0;
      endcase
      return l;
   endfunction

   function automatic logic [7:0] pat_char(input logic [4:0] p, input logic [3:0] i);
      logic [95:0] t;
      logic [3:0]  l;
      logic [6:0]  sh;
      logic [95:0] s;
      t  = pat_text(p);
      l  = pat_len(p);
      sh = {l - 4'd1 - i, 3'b000};
      s  = t >> sh;
      return s[7:0];
   endfunction

endpackage

// File: rtl/arlt_matcher.sv
// arlt_matcher: walks a finished line one character per step against the response patterns
// depends on arlt_pkg

module arlt_matcher #(
   parameter int LEN_W = 9
) (
   input  logic                 clock,
   input  logic                 clear,
   input  logic                 step,
   input  logic [3:0]           idx,
   input  logic [7:0]           data,
   input  logic [LEN_W-1:0]     len,
   output arlt_pkg::class_type  cls
);
   import arlt_pkg::*;

   logic [NPAT-1:0] flag_ff;
   logic [NPAT-1:0] flag_in;
   logic [NPAT-1:0] sw;
   logic [NPAT-1:0] eq;

   always_comb begin
      flag_in = flag_ff;
      if (clear) begin
         flag_in = '1;
      end else if (step) begin
         for (int p = 0; p < NPAT; p++) begin
            if (idx < pat_len(5'(p)) && data != pat_char(5'(p), idx)) begin
               flag_in[p] = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      flag_ff <= flag_in;
   end

   always_comb begin
      for (int p = 0; p < NPAT; p++) begin
         sw[p] = flag_ff[p] && (len >= LEN_W'(pat_len(5'(p))));
         eq[p] = flag_ff[p] && (len == LEN_W'(pat_len(5'(p))));
      end
      cls.echo      = sw[PAT_AT];
      cls.final_rsp = eq[PAT_OK] | eq[PAT_ERROR] | sw[PAT_CME] | sw[PAT_CMS]
                    | eq[PAT_SEND_OK] | eq[PAT_SEND_FAIL];
      cls.fail      = eq[PAT_ERROR] | sw[PAT_CME];
      cls.urc       = |sw[NPAT-1:PAT_URC_FIRST];
   end

endmodule

// File: rtl/at_response_line_tracker.sv
// at_response_line_tracker: assembles modem lines in a line memory, matches them against
// the oldest pending command and ages the pending table. depends on arlt_pkg, arlt_matcher
// a newline trims leading spaces, then trailing spaces, then checks up to 12 characters,
// one per read and check state pair; an empty line or one of only spaces ends after the
// leading trim and a '>' skips both trims; a tick reports each expired command in turn;
// a result that waits in the one output register for rsp_tready stalls the next result
// and holds the input off; synchronous active-high reset empties the line and the pending
// table and sets the next identifier to one; the line memory is not cleared

module at_response_line_tracker #(
   parameter int MAX_LINE      = 256,
   parameter int PENDING_DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // rx_byte[7:0], timeout_ms[39:8]
   input  logic [1:0]  req_tuser,  // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,  // command_id, success, line_length, elapsed_ms, truncated
   output logic [2:0]  rsp_tuser,  // kind[2:0]
   output logic        rsp_tlast
);
   import arlt_pkg::*;

   localparam int AW  = $clog2(MAX_LINE);
   localparam int CW  = $clog2(MAX_LINE + 1);
   localparam int PD  = PENDING_DEPTH;
   localparam int PIW = (PD > 1) ? $clog2(PD) : 1;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in, s_ff, s_in, e_ff, e_in;
   logic          ovf_ff, ovf_in, no_trim_ff, no_trim_in, last_gt_ff, last_gt_in;
   logic [3:0]    mi_ff, mi_in;
   logic [31:0]   tmo_ff, tmo_in, next_id_ff, next_id_in;
   logic [PD-1:0] valid_ff, valid_in, mask_ff, mask_in, mask_age;
   logic [31:0]   id_ff [PD];
   logic [31:0]   id_in [PD];
   logic [31:0]   lim_ff [PD];
   logic [31:0]   lim_in [PD];
   logic [31:0]   el_ff [PD];
   logic [31:0]   el_in [PD];
   logic [31:0]   el_age [PD];

   logic          rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [2:0]    rsp_kind_ff, rsp_kind_in;
   logic [31:0]   rsp_id_ff, rsp_id_in, rsp_el_ff, rsp_el_in;
   logic          rsp_ok_ff, rsp_ok_in, rsp_tr_ff, rsp_tr_in;
   logic [8:0]    rsp_len_ff, rsp_len_in;

   logic [7:0]    line_mem [MAX_LINE];
   logic [7:0]    rd_data_ff;
   logic          rd_en, mem_we, m_clear, m_step;
   logic [AW-1:0] rd_addr;

   logic          req_fire, out_free, is_nl, is_gt, is_print, is_bs;
   logic [7:0]    rx_byte;
   op_type        op;
   logic [CW-1:0] len_w;
   logic [3:0]    mlen;
   logic [PIW-1:0] low_idx;
   class_type     cls;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rx_byte    = req_tdata[7:0];
   assign op         = op_type'(req_tuser);
   assign is_nl      = (rx_byte == CH_NL);
   assign is_gt      = (rx_byte == CH_GT);
   assign is_print   = (rx_byte >= CH_SP) && (rx_byte < CH_DEL);
   assign is_bs      = (rx_byte == CH_BS) || (rx_byte == CH_DEL);
   assign len_w      = e_ff - s_ff;
   assign mlen       = (len_w > CW'(PAT_LEN)) ? 4'(PAT_LEN) : len_w[3:0];

   // aging of every pending command on a tick
   always_comb begin
      for (int k = 0; k < PD; k++) begin
         el_age[k]   = (el_ff[k] != '1) ? el_ff[k] + 32'd1 : el_ff[k];
         mask_age[k] = valid_ff[k] && (el_age[k] > lim_ff[k]);
      end
   end

   always_comb begin
      low_idx = '0;
      for (int k = PD - 1; k >= 0; k--) begin
         if (mask_ff[k]) begin
            low_idx = PIW'(k);
         end
      end
   end

   arlt_matcher #(.LEN_W(CW)) u_matcher (
      .clock (clock),
      .clear (m_clear),
      .step  (m_step),
      .idx   (mi_ff),
      .data  (rd_data_ff),
      .len   (len_w),
      .cls   (cls)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (op)
                  OP_BYTE: begin
                     if (is_nl) begin
                        state_in = ST_TS_RD;
                     end else if (is_gt) begin
                        state_in = ST_TE_RD;
                     end
                  end
                  OP_REG:  state_in = ST_REG;
                  OP_TICK: state_in = (mask_age != '0) ? ST_TMO : ST_IDLE;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_REG:    if (out_free) state_in = ST_IDLE;
         ST_TS_RD:  state_in = (s_ff == e_ff) ? ST_IDLE : ST_TS_CK;
         ST_TS_CK:  state_in = (rd_data_ff == CH_SP) ? ST_TS_RD : ST_TE_RD;
         ST_TE_RD:  state_in = ST_TE_CK;
         ST_TE_CK: begin
            if (!no_trim_ff && rd_data_ff == CH_SP) begin
               state_in = ST_TE_RD;
            end else begin
               state_in = ST_M_RD;
            end
         end
         ST_M_RD:   state_in = (mi_ff == mlen) ? ST_DECIDE : ST_M_CK;
         ST_M_CK:   state_in = ST_M_RD;
         ST_DECIDE: if (out_free) state_in = ST_IDLE;
         ST_TMO:    if (out_free && $countones(mask_ff) == 1) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      s_in        = s_ff;
      e_in        = e_ff;
      no_trim_in  = no_trim_ff;
      last_gt_in  = last_gt_ff;
      mi_in       = mi_ff;
      tmo_in      = tmo_ff;
      next_id_in  = next_id_ff;
      valid_in    = valid_ff;
      mask_in     = mask_ff;
      id_in       = id_ff;
      lim_in      = lim_ff;
      el_in       = el_ff;
      mem_we      = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = '0;
      m_clear     = 1'b0;
      m_step      = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in = rsp_kind_ff;
      rsp_id_in   = rsp_id_ff;
      rsp_ok_in   = rsp_ok_ff;
      rsp_len_in  = rsp_len_ff;
      rsp_el_in   = rsp_el_ff;
      rsp_tr_in   = rsp_tr_ff;
      rsp_last_in = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (op)
                  OP_BYTE: begin
                     if (is_nl) begin
                        s_in       = '0;
                        e_in       = count_ff;
                        no_trim_in = 1'b0;
                     end else if (is_print) begin
                        if (count_ff < CW'(MAX_LINE)) begin
                           mem_we   = 1'b1;
                           count_in = count_ff + CW'(1);
                        end else begin
                           ovf_in = 1'b1;
                        end
                        if (is_gt) begin
                           s_in       = '0;
                           e_in       = count_in;
                           no_trim_in = 1'b1;
                        end
                     end else if (is_bs) begin
                        if (count_ff != '0) count_in = count_ff - CW'(1);
                     end
                  end
                  OP_REG:  tmo_in = req_tdata[39:8];
                  OP_TICK: begin
                     for (int k = 0; k < PD; k++) begin
                        if (valid_ff[k]) el_in[k] = el_age[k];
                     end
                     mask_in = mask_age;
                  end
                  default: ;
               endcase
            end
         end
         ST_REG: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b0;
               rsp_len_in   = '0;
               rsp_el_in    = '0;
               rsp_tr_in    = 1'b0;
               rsp_last_in  = 1'b1;
               if (valid_ff[PD-1]) begin
                  rsp_kind_in = KIND_FULL;
                  rsp_id_in   = '0;
               end else begin
                  rsp_kind_in = KIND_ACCEPTED;
                  rsp_id_in   = next_id_ff;
                  for (int k = 0; k < PD; k++) begin
                     if (!valid_ff[k] && (k == 0 || valid_ff[(k > 0) ? k - 1 : 0])) begin
                        valid_in[k] = 1'b1;
                        id_in[k]    = next_id_ff;
                        lim_in[k]   = tmo_ff;
                        el_in[k]    = '0;
                     end
                  end
                  next_id_in = (next_id_ff == '1) ? 32'd1 : next_id_ff + 32'd1;
               end
            end
         end
         ST_TS_RD: begin
            if (s_ff == e_ff) begin
               count_in = '0;
               ovf_in   = 1'b0;
            end else begin
               rd_en   = 1'b1;
               rd_addr = s_ff[AW-1:0];
            end
         end
         ST_TS_CK: begin
            if (rd_data_ff == CH_SP) s_in = s_ff + CW'(1);
         end
         ST_TE_RD: begin
            rd_en   = 1'b1;
            rd_addr = AW'(e_ff - CW'(1));
         end
         ST_TE_CK: begin
            if (!no_trim_ff && rd_data_ff == CH_SP) begin
               e_in = e_ff - CW'(1);
            end else begin
               last_gt_in = (rd_data_ff == CH_GT);
               mi_in      = '0;
               m_clear    = 1'b1;
            end
         end
         ST_M_RD: begin
            if (mi_ff != mlen) begin
               rd_en   = 1'b1;
               rd_addr = AW'(s_ff + CW'(mi_ff));
            end
         end
         ST_M_CK: begin
            m_step = 1'b1;
            mi_in  = mi_ff + 4'd1;
         end
         ST_DECIDE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_len_in   = 9'(len_w);
               rsp_tr_in    = ovf_ff;
               rsp_last_in  = 1'b1;
               rsp_ok_in    = 1'b0;
               rsp_el_in    = '0;
               rsp_id_in    = id_ff[0];
               count_in     = '0;
               ovf_in       = 1'b0;
               if (valid_ff[0]) begin
                  if (cls.echo) begin
                     rsp_kind_in = KIND_ECHO;
                  end else if (cls.final_rsp || last_gt_ff) begin
                     rsp_kind_in = KIND_FINAL;
                     rsp_ok_in   = !cls.fail;
                     rsp_el_in   = el_ff[0];
                     for (int k = 0; k < PD - 1; k++) begin
                        valid_in[k] = valid_ff[k+1];
                        id_in[k]    = id_ff[k+1];
                        lim_in[k]   = lim_ff[k+1];
                        el_in[k]    = el_ff[k+1];
                     end
                     valid_in[PD-1] = 1'b0;
                  end else begin
                     rsp_kind_in = KIND_DATA;
                  end
               end else begin
                  rsp_id_in   = '0;
                  rsp_kind_in = cls.urc ? KIND_URC : KIND_UNMATCHED;
               end
            end
         end
         ST_TMO: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_TIMEOUT;
               rsp_id_in    = id_ff[low_idx];
               rsp_el_in    = el_ff[low_idx];
               rsp_ok_in    = 1'b0;
               rsp_len_in   = '0;
               rsp_tr_in    = 1'b0;
               rsp_last_in  = ($countones(mask_ff) == 1);
               for (int k = 0; k < PD - 1; k++) begin
                  if (PIW'(k) >= low_idx) begin
                     valid_in[k] = valid_ff[k+1];
                     id_in[k]    = id_ff[k+1];
                     lim_in[k]   = lim_ff[k+1];
                     el_in[k]    = el_ff[k+1];
                     mask_in[k]  = mask_ff[k+1];
                  end
               end
               valid_in[PD-1] = 1'b0;
               mask_in[PD-1]  = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[count_ff[AW-1:0]] <= rx_byte;
      end
      if (rd_en) begin
         rd_data_ff <= line_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         valid_ff     <= '0;
         mask_ff      <= '0;
         next_id_ff   <= 32'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         valid_ff     <= valid_in;
         mask_ff      <= mask_in;
         next_id_ff   <= next_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff        <= s_in;
      e_ff        <= e_in;
      no_trim_ff  <= no_trim_in;
      last_gt_ff  <= last_gt_in;
      mi_ff       <= mi_in;
      tmo_ff      <= tmo_in;
      id_ff       <= id_in;
      lim_ff      <= lim_in;
      el_ff       <= el_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_el_ff   <= rsp_el_in;
      rsp_tr_ff   <= rsp_tr_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {5'b0, rsp_tr_ff, rsp_el_ff, rsp_len_ff, rsp_ok_ff, rsp_id_ff};

endmodule
